### sv/fifo_lot_position_keeper_core_defines.svh
// Assertion macros for the position keeper checkers
`ifndef FIFO_LOT_POSITION_KEEPER_CORE_DEFINES_SVH
`define FIFO_LOT_POSITION_KEEPER_CORE_DEFINES_SVH

// same-cycle implication
`define FLPK_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FLPK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/flpk_pkg.sv
package flpk_pkg;

    localparam int NUM_INSTRUMENTS = 16;
    localparam int MAX_LOTS        = 64;

    localparam int SLOT_W = $clog2(NUM_INSTRUMENTS);
    localparam int HEAD_W = $clog2(MAX_LOTS);
    localparam int CNT_W  = $clog2(MAX_LOTS + 1);
    localparam int ADDR_W = $clog2(NUM_INSTRUMENTS * MAX_LOTS);
    localparam int LOT_W  = 56;

    localparam int IN_TDATA_W  = 168;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 192;
    localparam int OUT_TUSER_W = 4;

    localparam logic [1:0] REQ_REGISTER = 2'd0;
    localparam logic [1:0] REQ_FILL     = 2'd1;
    localparam logic [1:0] REQ_QUERY    = 2'd2;
    localparam logic [1:0] REQ_RESERVED = 2'd3;

    localparam logic [1:0] SIDE_NONE = 2'd0;
    localparam logic [1:0] SIDE_BUY  = 2'd1;
    localparam logic [1:0] SIDE_SELL = 2'd2;
    localparam logic [1:0] SIDE_BAD  = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_META  = 3'd1;
    localparam logic [2:0] ST_DUPLICATE = 3'd2;
    localparam logic [2:0] ST_TBL_FULL  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN   = 3'd4;
    localparam logic [2:0] ST_BAD_FILL  = 3'd5;
    localparam logic [2:0] ST_PNL_OVF   = 3'd6;
    localparam logic [2:0] ST_LOTS_FULL = 3'd7;

endpackage

### sv/flpk_ram.sv
module flpk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/fifo_lot_position_keeper_core.sv
// channel   | group  | tdata                                      | tuser
// ----------+--------+--------------------------------------------+------------------
// requests  | s_axis | id, side, price, qty, mult, tick, scale    | req_type
// results   | m_axis | net, realized, open qty, open weighted     | status, found
//
// Register, query and rejected requests pass LOOKUP, DISP and DONE before the result is valid.
// Fill: nothing to close runs APPMUL and COMMIT; each lot closed adds RD, EVAL, MUL1, MUL2 and
// UPD (read, multiply, write back), a same-side head lot RD and EVAL; lots full ends in EVAL,
// overflow in UPD. Items are taken in idle only, one at a time, after the last leaves DONE.
// Reset clears the state, the output valid and the slot valid bits; the lot memory needs none.
// A result waiting on m_axis_tready holds; the next result waits in done until it drains.
module fifo_lot_position_keeper_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // instrument id, side, price, quantity, multiplier, tick size, scale
    input  logic [flpk_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // req_type
    input  logic [flpk_pkg::IN_TUSER_W-1:0]      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // net_position, realized_sum, open_qty_total, open_weighted_total
    output logic [flpk_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    // status, found
    output logic [flpk_pkg::OUT_TUSER_W-1:0]     m_axis_tuser
);

    localparam int NUM    = flpk_pkg::NUM_INSTRUMENTS;
    localparam int MAXL   = flpk_pkg::MAX_LOTS;
    localparam int SLOT_W = flpk_pkg::SLOT_W;
    localparam int HEAD_W = flpk_pkg::HEAD_W;
    localparam int CNT_W  = flpk_pkg::CNT_W;
    localparam int ADDR_W = flpk_pkg::ADDR_W;
    localparam int LOT_W  = flpk_pkg::LOT_W;

    typedef enum logic [10:0] {
        S_IDLE   = 11'b00000000001,
        S_LOOKUP = 11'b00000000010,
        S_DISP   = 11'b00000000100,
        S_RD     = 11'b00000001000,
        S_EVAL   = 11'b00000010000,
        S_MUL1   = 11'b00000100000,
        S_MUL2   = 11'b00001000000,
        S_UPD    = 11'b00010000000,
        S_APPMUL = 11'b00100000000,
        S_COMMIT = 11'b01000000000,
        S_DONE   = 11'b10000000000
    } state_t;

    function automatic logic [ADDR_W-1:0] lot_addr(input logic [SLOT_W-1:0] s,
                                                   input logic [HEAD_W-1:0] h);
        return ADDR_W'(s) * ADDR_W'(MAXL) + ADDR_W'(h);
    endfunction

    state_t state_reg;

    logic [1:0]  req_type_reg;
    logic [30:0] id_reg;
    logic [1:0]  side_reg;
    logic [30:0] price_reg;
    logic [23:0] qty_reg;
    logic [15:0] mult_in_reg;
    logic        tick_nz_reg;
    logic        scale_nz_reg;

    logic              slot_valid_reg [NUM];
    logic [30:0]       slot_id_reg    [NUM];
    logic [15:0]       slot_mult_reg  [NUM];
    logic [HEAD_W-1:0] head_reg       [NUM];
    logic [CNT_W-1:0]  count_reg      [NUM];
    logic [31:0]       net_reg        [NUM];
    logic [63:0]       real_reg       [NUM];
    logic [30:0]       oq_reg         [NUM];
    logic [61:0]       ow_reg         [NUM];

    logic              hit_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic              free_ok_reg;
    logic [SLOT_W-1:0] free_reg;

    logic [HEAD_W-1:0] w_head_reg;
    logic [CNT_W-1:0]  w_count_reg;
    logic [23:0]       w_rem_reg;
    logic [63:0]       w_real_reg;
    logic [30:0]       w_oq_reg;
    logic [61:0]       w_ow_reg;
    logic [15:0]       w_mult_reg;
    logic              new_sell_reg;

    logic [30:0] e_price_reg;
    logic [23:0] e_qty_reg;
    logic [23:0] close_reg;
    logic [30:0] mag_reg;
    logic        neg_reg;
    logic [54:0] p_reg;
    logic [54:0] lpc_reg;
    logic [70:0] pm_reg;
    logic [54:0] app_reg;

    logic [2:0]  res_status_reg;
    logic        res_found_reg;
    logic [31:0] res_net_reg;
    logic [63:0] res_real_reg;
    logic [30:0] res_oq_reg;
    logic [60:0] res_ow_reg;

    logic        out_valid_reg;
    logic [2:0]  out_status_reg;
    logic        out_found_reg;
    logic [31:0] out_net_reg;
    logic [63:0] out_real_reg;
    logic [30:0] out_oq_reg;
    logic [60:0] out_ow_reg;

    logic              lk_hit;
    logic [SLOT_W-1:0] lk_slot;
    logic              lk_free_ok;
    logic [SLOT_W-1:0] lk_free;

    logic [2:0]  disp_status;
    logic        reg_go;
    logic        fill_go;
    logic        query_hit;
    logic        out_load;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [LOT_W-1:0]  ram_wdata;
    logic [LOT_W-1:0]  ram_rdata;

    logic        e_sell;
    logic [30:0] e_price;
    logic [23:0] e_qty;
    logic [63:0] room;
    logic        ovf;
    logic [23:0] rem_after;
    logic        lot_empties;
    logic [HEAD_W-1:0] head_inc;
    logic [CNT_W:0]    pos_sum;
    logic [HEAD_W-1:0] app_pos;
    logic [CNT_W-1:0]  c_count;
    logic [30:0]       c_oq;
    logic [61:0]       c_ow;
    logic [31:0]       c_net;

    flpk_ram #(
        .WIDTH (LOT_W),
        .DEPTH (NUM * MAXL)
    ) u_lot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (lot_addr(slot_reg, w_head_reg)),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        lk_hit     = 1'b0;
        lk_slot    = '0;
        lk_free_ok = 1'b0;
        lk_free    = '0;
        for (int i = NUM - 1; i >= 0; i--)
        begin
            if (slot_valid_reg[i] && slot_id_reg[i] == id_reg)
            begin
                lk_hit  = 1'b1;
                lk_slot = SLOT_W'(i);
            end
            if (!slot_valid_reg[i])
            begin
                lk_free_ok = 1'b1;
                lk_free    = SLOT_W'(i);
            end
        end
    end

    always_comb
    begin
        disp_status = flpk_pkg::ST_OK;
        case (req_type_reg)
            flpk_pkg::REQ_REGISTER:
            begin
                if (id_reg == '0 || mult_in_reg == '0 || !tick_nz_reg || !scale_nz_reg)
                begin
                    disp_status = flpk_pkg::ST_BAD_META;
                end
                else if (hit_reg)
                begin
                    disp_status = flpk_pkg::ST_DUPLICATE;
                end
                else if (!free_ok_reg)
                begin
                    disp_status = flpk_pkg::ST_TBL_FULL;
                end
            end
            flpk_pkg::REQ_FILL:
            begin
                if (!hit_reg)
                begin
                    disp_status = flpk_pkg::ST_UNKNOWN;
                end
                else if (side_reg == flpk_pkg::SIDE_NONE || side_reg == flpk_pkg::SIDE_BAD
                         || price_reg == '0 || qty_reg == '0)
                begin
                    disp_status = flpk_pkg::ST_BAD_FILL;
                end
            end
            default:
            begin
                disp_status = flpk_pkg::ST_OK;
            end
        endcase
    end

    assign reg_go    = req_type_reg == flpk_pkg::REQ_REGISTER && disp_status == flpk_pkg::ST_OK;
    assign fill_go   = req_type_reg == flpk_pkg::REQ_FILL && disp_status == flpk_pkg::ST_OK;
    assign query_hit = req_type_reg == flpk_pkg::REQ_QUERY && hit_reg;
    assign out_load  = state_reg == S_DONE && (!out_valid_reg || m_axis_tready);

    assign e_sell  = ram_rdata[55];
    assign e_price = ram_rdata[54:24];
    assign e_qty   = ram_rdata[23:0];

    assign room        = neg_reg ? (w_real_reg + 64'h8000_0000_0000_0000)
                                 : (64'h7FFF_FFFF_FFFF_FFFF - w_real_reg);
    assign ovf         = pm_reg > {7'd0, room};
    assign rem_after   = w_rem_reg - close_reg;
    assign lot_empties = e_qty_reg == close_reg;
    assign head_inc    = (w_head_reg == HEAD_W'(MAXL - 1)) ? '0 : w_head_reg + 1'b1;
    assign pos_sum     = (CNT_W + 1)'(w_head_reg) + (CNT_W + 1)'(w_count_reg);
    assign app_pos     = (pos_sum >= (CNT_W + 1)'(MAXL)) ? HEAD_W'(pos_sum - (CNT_W + 1)'(MAXL))
                                                         : HEAD_W'(pos_sum);
    assign c_count     = (w_rem_reg != '0) ? w_count_reg + 1'b1 : w_count_reg;
    assign c_oq        = w_oq_reg + 31'(w_rem_reg);
    assign c_ow        = w_ow_reg + 62'(app_reg);
    assign c_net       = new_sell_reg ? net_reg[slot_reg] - 32'(qty_reg)
                                      : net_reg[slot_reg] + 32'(qty_reg);

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = lot_addr(slot_reg, w_head_reg);
        ram_wdata = {~new_sell_reg, e_price_reg, e_qty_reg - close_reg};
        case (state_reg)
            S_UPD:
            begin
                ram_we = !ovf && !lot_empties;
            end
            S_COMMIT:
            begin
                ram_we    = w_rem_reg != '0;
                ram_waddr = lot_addr(slot_reg, app_pos);
                ram_wdata = {new_sell_reg, price_reg, w_rem_reg};
            end
            default:
            begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM; i++)
            begin
                slot_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid)
                    begin
                        state_reg <= S_LOOKUP;
                    end
                end
                S_LOOKUP:
                begin
                    state_reg <= S_DISP;
                end
                S_DISP:
                begin
                    if (reg_go)
                    begin
                        slot_valid_reg[free_reg] <= 1'b1;
                    end
                    if (fill_go)
                    begin
                        state_reg <= (count_reg[slot_reg] != '0) ? S_RD : S_APPMUL;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_RD:
                begin
                    state_reg <= S_EVAL;
                end
                S_EVAL:
                begin
                    if (e_sell == new_sell_reg)
                    begin
                        state_reg <= (w_count_reg == CNT_W'(MAXL)) ? S_DONE : S_APPMUL;
                    end
                    else
                    begin
                        state_reg <= S_MUL1;
                    end
                end
                S_MUL1:
                begin
                    state_reg <= S_MUL2;
                end
                S_MUL2:
                begin
                    state_reg <= S_UPD;
                end
                S_UPD:
                begin
                    if (ovf)
                    begin
                        state_reg <= S_DONE;
                    end
                    else if (lot_empties && rem_after != '0 && w_count_reg != CNT_W'(1))
                    begin
                        state_reg <= S_RD;
                    end
                    else
                    begin
                        state_reg <= S_APPMUL;
                    end
                end
                S_APPMUL:
                begin
                    state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                req_type_reg <= s_axis_tuser;
                id_reg       <= s_axis_tdata[30:0];
                side_reg     <= s_axis_tdata[32:31];
                price_reg    <= s_axis_tdata[63:33];
                qty_reg      <= s_axis_tdata[87:64];
                mult_in_reg  <= s_axis_tdata[103:88];
                tick_nz_reg  <= s_axis_tdata[134:104] != '0;
                scale_nz_reg <= s_axis_tdata[165:135] != '0;
            end
            S_LOOKUP:
            begin
                hit_reg     <= lk_hit;
                slot_reg    <= lk_slot;
                free_ok_reg <= lk_free_ok;
                free_reg    <= lk_free;
            end
            S_DISP:
            begin
                res_status_reg <= disp_status;
                res_found_reg  <= query_hit;
                res_net_reg    <= query_hit ? net_reg[slot_reg] : '0;
                res_real_reg   <= query_hit ? real_reg[slot_reg] : '0;
                res_oq_reg     <= query_hit ? oq_reg[slot_reg] : '0;
                res_ow_reg     <= query_hit ? ow_reg[slot_reg][60:0] : '0;
                w_head_reg     <= head_reg[slot_reg];
                w_count_reg    <= count_reg[slot_reg];
                w_real_reg     <= real_reg[slot_reg];
                w_oq_reg       <= oq_reg[slot_reg];
                w_ow_reg       <= ow_reg[slot_reg];
                w_mult_reg     <= slot_mult_reg[slot_reg];
                w_rem_reg      <= qty_reg;
                new_sell_reg   <= side_reg == flpk_pkg::SIDE_SELL;
                if (reg_go)
                begin
                    slot_id_reg[free_reg]   <= id_reg;
                    slot_mult_reg[free_reg] <= mult_in_reg;
                    head_reg[free_reg]      <= '0;
                    count_reg[free_reg]     <= '0;
                    net_reg[free_reg]       <= '0;
                    real_reg[free_reg]      <= '0;
                    oq_reg[free_reg]        <= '0;
                    ow_reg[free_reg]        <= '0;
                end
            end
            S_EVAL:
            begin
                e_price_reg <= e_price;
                e_qty_reg   <= e_qty;
                close_reg   <= (w_rem_reg < e_qty) ? w_rem_reg : e_qty;
                if (!e_sell)
                begin
                    neg_reg <= price_reg < e_price;
                end
                else
                begin
                    neg_reg <= e_price < price_reg;
                end
                mag_reg <= (price_reg < e_price) ? e_price - price_reg : price_reg - e_price;
                if (e_sell == new_sell_reg && w_count_reg == CNT_W'(MAXL))
                begin
                    res_status_reg <= flpk_pkg::ST_LOTS_FULL;
                end
            end
            S_MUL1:
            begin
                p_reg   <= 55'(mag_reg) * 55'(close_reg);
                lpc_reg <= 55'(e_price_reg) * 55'(close_reg);
            end
            S_MUL2:
            begin
                pm_reg <= 71'(p_reg) * 71'(w_mult_reg);
            end
            S_UPD:
            begin
                if (ovf)
                begin
                    res_status_reg      <= flpk_pkg::ST_PNL_OVF;
                    head_reg[slot_reg]  <= w_head_reg;
                    count_reg[slot_reg] <= w_count_reg;
                    real_reg[slot_reg]  <= w_real_reg;
                    oq_reg[slot_reg]    <= w_oq_reg;
                    ow_reg[slot_reg]    <= w_ow_reg;
                end
                else
                begin
                    w_real_reg <= neg_reg ? w_real_reg - pm_reg[63:0]
                                          : w_real_reg + pm_reg[63:0];
                    w_oq_reg   <= w_oq_reg - 31'(close_reg);
                    w_ow_reg   <= w_ow_reg - 62'(lpc_reg);
                    w_rem_reg  <= rem_after;
                    if (lot_empties)
                    begin
                        w_head_reg  <= head_inc;
                        w_count_reg <= w_count_reg - 1'b1;
                    end
                end
            end
            S_APPMUL:
            begin
                app_reg <= 55'(price_reg) * 55'(w_rem_reg);
            end
            S_COMMIT:
            begin
                head_reg[slot_reg]  <= w_head_reg;
                count_reg[slot_reg] <= c_count;
                real_reg[slot_reg]  <= w_real_reg;
                oq_reg[slot_reg]    <= c_oq;
                ow_reg[slot_reg]    <= c_ow;
                net_reg[slot_reg]   <= c_net;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_status_reg <= res_status_reg;
                    out_found_reg  <= res_found_reg;
                    out_net_reg    <= res_net_reg;
                    out_real_reg   <= res_real_reg;
                    out_oq_reg     <= res_oq_reg;
                    out_ow_reg     <= res_ow_reg;
                end
            end
            default:
            begin
                hit_reg <= hit_reg;
            end
        endcase
    end

    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = {out_found_reg, out_status_reg};
    assign m_axis_tdata  = {4'd0, out_ow_reg, out_oq_reg, out_real_reg, out_net_reg};

endmodule

### sv/flpk_checker.sv
`include "fifo_lot_position_keeper_core_defines.svh"

module flpk_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic [flpk_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input logic [flpk_pkg::IN_TUSER_W-1:0]  s_axis_tuser,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [flpk_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    input logic [flpk_pkg::OUT_TUSER_W-1:0] m_axis_tuser
);

    `FLPK_ASSERT_NEXT(a_one_item_in_flight, (s_axis_tvalid && s_axis_tready), (!s_axis_tready), "item accepted while busy")

    `FLPK_ASSERT_IMPLY(a_error_clears_payload, (m_axis_tvalid && m_axis_tuser[2:0] != flpk_pkg::ST_OK), (!m_axis_tuser[3] && m_axis_tdata == '0), "error result carries data")

    `FLPK_ASSERT_NEXT(a_result_holds, (m_axis_tvalid && !m_axis_tready), (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result changed")

endmodule

bind fifo_lot_position_keeper_core flpk_checker u_flpk_checker (.*);
